### design/assert_macros.svh
// Assertion macros shared by the stencil engine RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every rising edge outside reset.
`define PAS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("stencil engine assertion failed");
// Condition must never be seen at a rising edge outside reset.
`define PAS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("stencil engine forbidden condition seen");
`else
`define PAS_ASSERT(lbl, clk, rst_n, prop)
`define PAS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### design/pas_pkg.sv
// Types, codes and per-pass decode for the periodic advection stencil engine.
// No dependencies; used by pas_cell, pas_stencil and the top level.
package pas_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COURANT_W  = 16;
  localparam int INDEX_W    = 10;
  localparam int METHOD_W   = 3;
  localparam int POINTS_W   = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int BIAS_W     = 18;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_ADVANCE = 2'd1,
    REQ_READ    = 2'd2
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_METHOD  = 2'd0,
    CFG_COURANT = 2'd1,
    CFG_POINTS  = 2'd2
  } cfg_idx_e;

  typedef enum logic [METHOD_W-1:0] {
    METH_LW   = 3'd0,
    METH_RK2  = 3'd1,
    METH_RK3  = 3'd2,
    METH_RK3V = 3'd3,
    METH_RK4  = 3'd4
  } method_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [INDEX_W-1:0] point_index;
    sample_t            point_value;
  } req_t;

  typedef struct packed {
    sample_t read_value;
    logic    step_done;
    logic    saturated;
  } res_t;

  // Control for one pass over the grid
  typedef struct packed {
    logic              lax;        // Lax-Wendroff update, else Runge-Kutta stage
    logic              div3;       // stage divisor holds a factor of three
    logic [1:0]        shift_sel;  // divisor power of two is 2^(16+shift_sel)
    logic [BIAS_W-1:0] bias;       // rounding bias, half the divisor
    logic              wr_cur;     // pass writes the current grid
  } pass_ctl_t;

  // Decode a Runge-Kutta stage divisor n (stage factor 1/n)
  function automatic pass_ctl_t rk_ctl(input logic [2:0] denom);
    pass_ctl_t c;
    c = '0;
    c.wr_cur = 1'b1;
    case (denom)
      3'd2: begin
        c.shift_sel = 2'd1;
        c.bias      = BIAS_W'(65536);
      end
      3'd3: begin
        c.div3      = 1'b1;
        c.bias      = BIAS_W'(98304);
      end
      3'd4: begin
        c.shift_sel = 2'd2;
        c.bias      = BIAS_W'(131072);
      end
      3'd6: begin
        c.div3      = 1'b1;
        c.shift_sel = 2'd1;
        c.bias      = BIAS_W'(196608);
      end
      default: begin
        c.bias      = BIAS_W'(32768);
      end
    endcase
    return c;
  endfunction

  // Control of pass sidx for a method; unknown methods only copy
  function automatic pass_ctl_t stage_ctl(input logic [METHOD_W-1:0] method,
                                          input logic [1:0] sidx);
    pass_ctl_t c;
    c = '0;
    unique case (method)
      METH_LW: begin
        c.lax    = 1'b1;
        c.wr_cur = 1'b1;
      end
      METH_RK2:  c = rk_ctl(3'(3'd2 - 3'(sidx)));
      METH_RK3:  c = rk_ctl(3'(3'd3 - 3'(sidx)));
      METH_RK3V: c = rk_ctl((sidx == 2'd0) ? 3'd6 : ((sidx == 2'd1) ? 3'd2 : 3'd1));
      METH_RK4:  c = rk_ctl(3'(3'd4 - 3'(sidx)));
      default:   c = '0;
    endcase
    return c;
  endfunction

  // Number of passes an advance takes
  function automatic logic [2:0] stage_total(input logic [METHOD_W-1:0] method);
    logic [2:0] n;
    n = 3'd1;
    unique case (method) inside
      METH_RK2:                  n = 3'd2;
      METH_RK3, METH_RK3V:       n = 3'd3;
      METH_RK4:                  n = 3'd4;
      default:                   n = 3'd1;
    endcase
    return n;
  endfunction

endpackage

### design/pas_cell.sv
// One cell of the stencil window: holds a sample and hands it on when shifted.
// Depends on pas_pkg for the sample type.
module pas_cell (
  input  logic             clk_i,
  input  logic             shift_i,
  input  pas_pkg::sample_t d_i,
  output pas_pkg::sample_t q_o
);
  import pas_pkg::*;

  sample_t val_q;

  // Take the neighbor's sample on each shift beat
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      val_q <= d_i;
    end
  end

  assign q_o = val_q;

endmodule

### design/pas_stencil.sv
// Five-stage arithmetic pipeline: one grid point per cycle, Lax-Wendroff or
// Runge-Kutta stage update with round-to-nearest and saturation. Uses pas_pkg.
module pas_stencil #(
  parameter int ADDR_W = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic [ADDR_W-1:0]                  in_addr_i,
  input  pas_pkg::pass_ctl_t                 ctl_i,
  input  logic [pas_pkg::COURANT_W-1:0]      courant_i,
  input  pas_pkg::sample_t                   um_i,
  input  pas_pkg::sample_t                   u0_i,
  input  pas_pkg::sample_t                   up_i,
  input  pas_pkg::sample_t                   old_i,
  output logic                               wr_en_o,
  output logic [ADDR_W-1:0]                  wr_addr_o,
  output pas_pkg::sample_t                   wr_data_o,
  output logic                               clip_o,
  output logic                               busy_o
);
  import pas_pkg::*;

  localparam int SMAX = (1 << (SAMPLE_W - 1)) - 1;
  localparam int SMIN = -(1 << (SAMPLE_W - 1));

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [ADDR_W-1:0] a1_q, a2_q, a3_q, a4_q, a5_q;
  sample_t u1_q, u2_q, u3_q, u4_q, u5_q;
  sample_t o1_q, o2_q, o3_q, o4_q, o5_q;

  logic signed [16:0] d1_q, d1b_q;
  logic signed [17:0] d2_q;
  logic signed [34:0] m2_q;
  logic signed [19:0] q3_q;
  logic [15:0]        r3_q;
  logic signed [17:0] t3_q, t4_q;
  logic signed [36:0] a4p_q;
  logic [31:0]        b4_q;
  logic [19:0]        vb4_q;
  logic [18:0]        q04_q;
  logic signed [23:0] adj_q;

  logic signed [16:0] c_s;
  logic signed [17:0] mop;
  logic signed [34:0] m2_d;
  logic signed [35:0] inner, rsum, tfull;
  logic signed [36:0] a4_d;
  logic [31:0]        b4_d;
  logic [19:0]        v4_d;
  logic [38:0]        prod4;
  logic [16:0]        bsh;
  logic signed [37:0] lsum, lsh;
  logic [19:0]        r3v, qa;
  logic signed [20:0] qq;
  logic signed [23:0] adj_d;
  logic signed [24:0] res;

  assign c_s = signed'({1'b0, courant_i});

  // Stage two operands: first difference or second difference
  assign mop  = ctl_i.lax ? d2_q : 18'(d1_q);
  assign m2_d = c_s * mop;

  // Stage three: split the Lax-Wendroff sum, or round-scale the stage slope
  assign inner = 36'(m2_q) - (36'(d1b_q) <<< 15);
  assign rsum  = 36'(m2_q) + signed'({18'b0, ctl_i.bias});
  assign tfull = rsum >>> (6'd16 + 6'(ctl_i.shift_sel));

  // Stage four: second products and the divide-by-three estimate
  assign a4_d  = c_s * q3_q;
  assign b4_d  = courant_i * r3_q;
  assign v4_d  = 20'(21'(t3_q) + 21'sd393216);
  assign prod4 = v4_d * 19'd349525;

  // Stage five: finish the Lax-Wendroff delta, or correct the quotient
  assign bsh  = 17'((33'(b4_q) + 33'h4000_0000) >> 16);
  assign lsum = 38'(a4p_q) + signed'({21'b0, bsh});
  assign lsh  = lsum >>> 15;
  assign r3v  = vb4_q - 20'({q04_q, 1'b0}) - 20'(q04_q);
  assign qa   = 20'(q04_q) + ((r3v >= 20'd3) ? 20'd1 : 20'd0);
  assign qq   = signed'({1'b0, qa}) - 21'sd131072;

  always_comb begin
    if (ctl_i.lax) begin
      adj_d = lsh[23:0];
    end else if (ctl_i.div3) begin
      adj_d = 24'(qq);
    end else begin
      adj_d = 24'(t4_q);
    end
  end

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    a1_q <= in_addr_i;
    u1_q <= u0_i;
    o1_q <= old_i;
    d1_q <= 17'(up_i) - 17'(um_i);
    d2_q <= 18'(um_i) + 18'(up_i) - (18'(u0_i) <<< 1);

    a2_q  <= a1_q;
    u2_q  <= u1_q;
    o2_q  <= o1_q;
    d1b_q <= d1_q;
    m2_q  <= m2_d;

    a3_q <= a2_q;
    u3_q <= u2_q;
    o3_q <= o2_q;
    q3_q <= inner[35:16];
    r3_q <= inner[15:0];
    t3_q <= tfull[17:0];

    a4_q  <= a3_q;
    u4_q  <= u3_q;
    o4_q  <= o3_q;
    a4p_q <= a4_d;
    b4_q  <= b4_d;
    vb4_q <= v4_d;
    q04_q <= prod4[38:20];
    t4_q  <= t3_q;

    a5_q  <= a4_q;
    u5_q  <= u4_q;
    o5_q  <= o4_q;
    adj_q <= adj_d;
  end

  // Apply the update and saturate
  assign res = ctl_i.lax ? (25'(u5_q) + 25'(adj_q)) : (25'(o5_q) - 25'(adj_q));

  always_comb begin
    if (res > 25'(SMAX)) begin
      wr_data_o = sample_t'(SMAX);
      clip_o    = wr_en_o;
    end else if (res < 25'(SMIN)) begin
      wr_data_o = sample_t'(SMIN);
      clip_o    = wr_en_o;
    end else begin
      wr_data_o = res[SAMPLE_W-1:0];
      clip_o    = 1'b0;
    end
  end

  assign wr_en_o   = v5_q && ctl_i.wr_cur;
  assign wr_addr_o = a5_q;
  assign busy_o    = v1_q | v2_q | v3_q | v4_q | v5_q;

endmodule

### design/periodic_advection_stencil_step.sv
// Periodic 1D advection stencil engine. A write's result beat appears the cycle
// after start; a read keeps busy high for one cycle and returns its beat from
// the S_READ state through the result register. An advance streams the grid
// through a three-cell window, one point per cycle from the grid memory read
// port, once per pass: the pass count is 1 for Lax-Wendroff, 2, 3, 3 or 4 for
// the Runge-Kutta methods, 1 for unknown codes. Each result beat is shown for
// exactly one cycle; the receiver cannot stall.
// Depends on pas_pkg, pas_cell, pas_stencil and assert_macros.svh.
`include "assert_macros.svh"

module periodic_advection_stencil_step #(
  parameter int GRID_DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  pas_pkg::req_t                     req_i,
  output logic                              res_valid_o,
  output pas_pkg::res_t                     res_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pas_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pas_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import pas_pkg::*;

  localparam int AW  = $clog2(GRID_DEPTH);
  localparam int CW  = $clog2(GRID_DEPTH + 2);
  localparam int WIN = 3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_STREAM,
    S_DRAIN
  } state_e;

  state_e state_q;

  logic [METHOD_W-1:0]  method_q;
  logic [COURANT_W-1:0] courant_q;
  logic [POINTS_W-1:0]  points_q;

  logic [CW-1:0] n_len, k_q, rd_k_q;
  logic [1:0]    sidx_q;
  logic          clip_q, rd_ok_q, res_valid_q;
  res_t          res_q;

  logic          acc, acc_wr, idx_ok;
  logic [AW-1:0] cur_raddr, prv_raddr, cur_waddr, win_j_q;
  logic          cur_we, prv_we, rd_v_q, win_v_q;
  sample_t       cur_wdata, cur_rd_q, prv_rd_q, prv_win_q, head_q, old_v;
  sample_t       chain [WIN+1];
  pass_ctl_t     ctl;

  logic          stn_wr_en, stn_clip, stn_busy;
  logic [AW-1:0] stn_addr;
  sample_t       stn_data;

  sample_t cur_mem [GRID_DEPTH];
  sample_t prev_mem [GRID_DEPTH];

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != S_IDLE);
  assign acc         = start && !busy;
  assign acc_wr      = acc && (req_i.req_type == REQ_WRITE);
  assign idx_ok      = (32'(req_i.point_index) < GRID_DEPTH);

  // Clamp grid length to [3, GRID_DEPTH]
  always_comb begin
    if (points_q < POINTS_W'(3)) begin
      n_len = CW'(3);
    end else if (32'(points_q) > GRID_DEPTH) begin
      n_len = CW'(GRID_DEPTH);
    end else begin
      n_len = CW'(points_q);
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q  <= METH_LW;
      courant_q <= COURANT_W'(16384);
      points_q  <= POINTS_W'(16);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_METHOD:  method_q  <= cfg_data_i[METHOD_W-1:0];
        CFG_COURANT: courant_q <= cfg_data_i[COURANT_W-1:0];
        CFG_POINTS:  points_q  <= cfg_data_i[POINTS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read addresses: wrapped stream order while streaming, request index otherwise
  always_comb begin
    if (state_q == S_STREAM) begin
      cur_raddr = (k_q == '0) ? AW'(n_len - CW'(1)) : AW'(k_q - CW'(1));
    end else begin
      cur_raddr = AW'(req_i.point_index);
    end
  end
  assign prv_raddr = AW'(k_q - CW'(2));

  // Current grid write: pipeline result or request write
  assign cur_we    = stn_wr_en || (acc_wr && idx_ok);
  assign cur_waddr = stn_wr_en ? stn_addr : AW'(req_i.point_index);
  assign cur_wdata = stn_wr_en ? stn_data : req_i.point_value;

  always_ff @(posedge clk_i) begin
    if (cur_we) begin
      cur_mem[cur_waddr] <= cur_wdata;
    end
    cur_rd_q <= cur_mem[cur_raddr];
  end

  // Previous grid: filled from the window center during the first pass
  assign prv_we = win_v_q && (sidx_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (prv_we) begin
      prev_mem[win_j_q] <= chain[2];
    end
    prv_rd_q <= prev_mem[prv_raddr];
  end

  // Read-beat and window valid tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q  <= 1'b0;
      win_v_q <= 1'b0;
    end else begin
      rd_v_q  <= (state_q == S_STREAM);
      win_v_q <= rd_v_q && (rd_k_q >= CW'(2));
    end
  end

  always_ff @(posedge clk_i) begin
    rd_k_q    <= k_q;
    win_j_q   <= AW'(rd_k_q - CW'(2));
    prv_win_q <= prv_rd_q;
    if (rd_v_q && (rd_k_q == CW'(1))) begin
      head_q <= cur_rd_q;
    end
  end

  // Window cells; the final beat replays the saved first point
  assign chain[0] = (rd_k_q == n_len + CW'(1)) ? head_q : cur_rd_q;

  for (genvar i = 0; i < WIN; i++) begin : g_win
    pas_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (rd_v_q),
      .d_i     (chain[i]),
      .q_o     (chain[i+1])
    );
  end

  assign ctl   = stage_ctl(method_q, sidx_q);
  assign old_v = (sidx_q == 2'd0) ? chain[2] : prv_win_q;

  pas_stencil #(
    .ADDR_W (AW)
  ) u_stencil (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (win_v_q),
    .in_addr_i  (win_j_q),
    .ctl_i      (ctl),
    .courant_i  (courant_q),
    .um_i       (chain[3]),
    .u0_i       (chain[2]),
    .up_i       (chain[1]),
    .old_i      (old_v),
    .wr_en_o    (stn_wr_en),
    .wr_addr_o  (stn_addr),
    .wr_data_o  (stn_data),
    .clip_o     (stn_clip),
    .busy_o     (stn_busy)
  );

  // Request sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      sidx_q      <= 2'd0;
      clip_q      <= 1'b0;
      rd_ok_q     <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      // Set the sticky clip flag on a clipped sample, clear it on a write
      if (stn_clip) begin
        clip_q <= 1'b1;
      end else if (acc_wr) begin
        clip_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            if (req_i.req_type == REQ_WRITE) begin
              res_q       <= '0;
              res_valid_q <= 1'b1;
            end else if (req_i.req_type == REQ_ADVANCE) begin
              k_q     <= '0;
              sidx_q  <= 2'd0;
              state_q <= S_STREAM;
            end else if (req_i.req_type == REQ_READ) begin
              rd_ok_q <= idx_ok;
              state_q <= S_READ;
            end else begin
              res_q       <= '{read_value: sample_t'(0), step_done: 1'b0, saturated: clip_q};
              res_valid_q <= 1'b1;
            end
          end
        end
        S_READ: begin
          res_q       <= '{read_value: (rd_ok_q ? cur_rd_q : sample_t'(0)),
                           step_done: 1'b0, saturated: clip_q};
          res_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        S_STREAM: begin
          k_q <= k_q + CW'(1);
          if (k_q == n_len + CW'(1)) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_v_q && !win_v_q && !stn_busy) begin
            if ({1'b0, sidx_q} + 3'd1 < stage_total(method_q)) begin
              sidx_q  <= sidx_q + 2'd1;
              k_q     <= '0;
              state_q <= S_STREAM;
            end else begin
              res_q       <= '{read_value: sample_t'(0), step_done: 1'b1, saturated: clip_q};
              res_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `PAS_ASSERT(a_wr_in_pass, clk_i, rst_ni, stn_wr_en |-> (state_q == S_STREAM || state_q == S_DRAIN))
  `PAS_ASSERT(a_clip_clear_on_write, clk_i, rst_ni, $fell(clip_q) |-> $past(acc_wr))
  `PAS_ASSERT_NEVER(a_issue_bound, clk_i, rst_ni, (state_q == S_STREAM) && (k_q > n_len + CW'(1)))
  `PAS_ASSERT(a_done_after_drain, clk_i, rst_ni, (res_valid_q && res_q.step_done) |-> $past(state_q == S_DRAIN))

endmodule

### tb/sv/periodic_advection_stencil_step_tb.sv
// Self-checking testbench for the periodic advection stencil engine: a queue-fed
// driver, a result monitor and a built-in grid predictor. Depends on pas_pkg.
module periodic_advection_stencil_step_tb;
  import pas_pkg::*;

  localparam int DEPTH = 1024;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [METHOD_W-1:0] METH_SPARE_LO = 3'd5;
  localparam logic [METHOD_W-1:0] METH_SPARE_HI = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_r = '0;
  logic res_valid_o;
  res_t res_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  periodic_advection_stencil_step #(.GRID_DEPTH(DEPTH)) u_dut (
    .clk_i, .rst_ni, .start, .busy, .req_i(req_r), .res_valid_o, .res_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: grid copies and live register settings
  longint cur_grid [DEPTH];
  longint prev_grid [DEPTH];
  longint diff_grid [DEPTH];
  bit clip_seen;
  logic [METHOD_W-1:0] meth_reg = METH_LW;
  logic [15:0] cfl_reg = 16'd16384;
  logic [POINTS_W-1:0] npts_reg = 11'd16;

  req_t pending_reqs[$];
  res_t expected_res[$];
  int idle_pct = 14;
  int mismatches = 0;
  int beats_checked = 0;
  int advances_sent = 0;

  // Generator view of which grid points hold data
  bit gen_written [DEPTH];
  int written_idx[$];
  int gen_n = 16;

  function automatic longint fdiv(longint x, longint d);
    longint q;
    q = x / d;
    if ((x % d) != 0 && x < 0) q--;
    return q;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) begin clip_seen = 1'b1; return 32767; end
    if (v < -32768) begin clip_seen = 1'b1; return -32768; end
    return v;
  endfunction

  function automatic int clamp_len(int n);
    if (n < 3) return 3;
    if (n > DEPTH) return DEPTH;
    return n;
  endfunction

  function automatic void lax_pass(int n);
    longint c, um, u0, up, d1, d2, inner, q, r, a, b;
    int jp, jm;
    c = longint'(cfl_reg);
    for (int j = 0; j < n; j++) begin
      jp = (j + 1 == n) ? 0 : j + 1;
      jm = (j == 0) ? n - 1 : j - 1;
      um = prev_grid[jm]; u0 = prev_grid[j]; up = prev_grid[jp];
      d1 = up - um;
      d2 = um - 2 * u0 + up;
      inner = -d1 * 32768 + c * d2;
      q = fdiv(inner, 65536);
      r = inner - q * 65536;
      a = c * q;
      b = c * r + (longint'(1) << 30);
      cur_grid[j] = clip16(u0 + fdiv(a + fdiv(b, 65536), 32768));
    end
  endfunction

  function automatic void rk_pass(int n, longint denom);
    longint c, scale;
    int jp, jm;
    c = longint'(cfl_reg);
    scale = denom * 65536;
    for (int j = 0; j < n; j++) begin
      jp = (j + 1 == n) ? 0 : j + 1;
      jm = (j == 0) ? n - 1 : j - 1;
      diff_grid[j] = cur_grid[jp] - cur_grid[jm];
    end
    for (int j = 0; j < n; j++)
      cur_grid[j] = clip16(prev_grid[j] - fdiv(2 * c * diff_grid[j] + scale, 2 * scale));
  endfunction

  // Compute the result beat of one accepted request and update the grid
  function automatic res_t grid_response(req_t rq);
    res_t rs;
    int n;
    rs = '0;
    case (rq.req_type)
      REQ_WRITE: begin
        clip_seen = 1'b0;
        cur_grid[rq.point_index] = clip16(longint'(rq.point_value));
      end
      REQ_ADVANCE: begin
        n = clamp_len(int'(npts_reg));
        for (int j = 0; j < n; j++) prev_grid[j] = cur_grid[j];
        case (meth_reg)
          METH_LW: lax_pass(n);
          METH_RK2: begin rk_pass(n, 2); rk_pass(n, 1); end
          METH_RK3: begin rk_pass(n, 3); rk_pass(n, 2); rk_pass(n, 1); end
          METH_RK3V: begin rk_pass(n, 6); rk_pass(n, 2); rk_pass(n, 1); end
          METH_RK4: begin rk_pass(n, 4); rk_pass(n, 3); rk_pass(n, 2); rk_pass(n, 1); end
          default: ;
        endcase
        rs.step_done = 1'b1;
      end
      REQ_READ: rs.read_value = sample_t'(cur_grid[rq.point_index]);
      default: ;
    endcase
    rs.saturated = clip_seen;
    return rs;
  endfunction

  // Driver: predict on each accepted beat, then offer the next pending request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_res = {expected_res, grid_response(req_r)};
      if (!start || !busy) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          req_r <= pending_reqs.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", res_o);
      end else begin
        want = expected_res.pop_front();
        beats_checked++;
        if (res_o.read_value !== want.read_value || res_o.step_done !== want.step_done ||
            res_o.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %0d done %b sat %b, got %0d %b %b",
                     want.read_value, want.step_done, want.saturated,
                     res_o.read_value, res_o.step_done, res_o.saturated);
        end
      end
    end
  end

  // Write one register through the config channel
  task automatic cfg_write(cfg_idx_e idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_METHOD: meth_reg = data[METHOD_W-1:0];
      CFG_COURANT: cfl_reg = data;
      CFG_POINTS: npts_reg = data[POINTS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || start || expected_res.size() > 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic push_req(logic [1:0] kind, int idx, int val);
    req_t rq;
    rq.req_type = kind;
    rq.point_index = INDEX_W'(idx);
    rq.point_value = sample_t'(val);
    if (kind == REQ_WRITE && !gen_written[idx]) begin
      gen_written[idx] = 1'b1;
      written_idx = {written_idx, idx};
    end
    if (kind == REQ_ADVANCE) advances_sent++;
    pending_reqs = {pending_reqs, rq};
  endtask

  function automatic int rand_sample();
    case ($urandom_range(5))
      0: return 32767;
      1: return -32768;
      2: return $urandom_range(200) - 100;
      default: return int'($signed(16'($urandom())));
    endcase
  endfunction

  // Give every point of the active grid a value so an advance reads no holes
  task automatic fill_grid();
    for (int j = 0; j < gen_n; j++)
      if (!gen_written[j]) push_req(REQ_WRITE, j, $urandom_range(4000) - 2000);
  endtask

  task automatic random_reqs(int count);
    int sel;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 35)
        push_req(REQ_WRITE, (sel < 8) ? $urandom_range(DEPTH - 1) : $urandom_range(gen_n - 1),
                 rand_sample());
      else if (sel < 55)
        push_req(REQ_ADVANCE, $urandom_range(DEPTH - 1), rand_sample());
      else if (sel < 95)
        push_req(REQ_READ, written_idx[$urandom_range(written_idx.size() - 1)], rand_sample());
      else
        push_req(REQ_UNUSED, $urandom_range(DEPTH - 1), rand_sample());
    end
  endtask

  task automatic set_phase(logic [2:0] m, logic [15:0] c, logic [15:0] p);
    wait_idle();
    cfg_write(CFG_METHOD, 16'(m));
    cfg_write(CFG_COURANT, c);
    cfg_write(CFG_POINTS, p);
    gen_n = clamp_len(int'(p[POINTS_W-1:0]));
    fill_grid();
  endtask

  initial begin
    logic [2:0] ph_m [7] = '{METH_LW, METH_RK2, METH_RK3, METH_RK3V, METH_RK4, METH_RK4, METH_RK3};
    logic [15:0] ph_c [7] = '{16'd16384, 16'd32768, 16'd0, 16'd20000, 16'hFFFF, 16'd32768,
                              16'd9000};
    logic [15:0] ph_p [7] = '{16'd16, 16'd8, 16'd5, 16'd0, 16'd12, 16'd40, 16'd3};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: extremes, clipping on advance, clear on write, odd codes
    set_phase(METH_LW, 16'd16384, 16'd3);
    push_req(REQ_WRITE, 0, 32767);
    push_req(REQ_WRITE, 1, -32768);
    push_req(REQ_WRITE, 2, 1);
    push_req(REQ_WRITE, 1023, -1);
    push_req(REQ_READ, 1023, 0);
    push_req(REQ_READ, 0, 0);
    push_req(REQ_ADVANCE, 0, 0);
    push_req(REQ_READ, 1, 0);
    push_req(REQ_UNUSED, 1023, -32768);
    wait_idle();
    cfg_write(CFG_COURANT, 16'hFFFF);
    push_req(REQ_ADVANCE, 0, 0);
    push_req(REQ_READ, 0, 0);
    push_req(REQ_READ, 2, 0);
    push_req(REQ_WRITE, 2, 5);
    push_req(REQ_READ, 2, 0);
    wait_idle();
    cfg_write(CFG_METHOD, 16'(METH_SPARE_HI));
    push_req(REQ_ADVANCE, 0, 0);
    push_req(REQ_READ, 1, 0);
    wait_idle();
    cfg_write(CFG_METHOD, 16'(METH_SPARE_LO));
    push_req(REQ_ADVANCE, 0, 0);
    push_req(REQ_READ, 0, 0);

    // Random phases over the register settings
    for (int ph = 0; ph < 7; ph++) begin
      set_phase(ph_m[ph], ph_c[ph], ph_p[ph]);
      idle_pct = (ph < 3) ? 14 : ((ph < 5) ? 53 : 0);
      random_reqs(12);
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (expected_res.size() > 0) mismatches++;
    $display("covered %0d result beats incl. %0d advances over all methods,", beats_checked,
             advances_sent);
    $display("grid lengths 3 to 40 and Courant numbers 0 to above one");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hold a hard stop far beyond the slowest legal run
  initial begin
    #50000000;
    $display("status: fail");
    $finish;
  end

endmodule

### files.f
+incdir+design
design/pas_pkg.sv
design/pas_cell.sv
design/pas_stencil.sv
design/periodic_advection_stencil_step.sv
tb/sv/periodic_advection_stencil_step_tb.sv
